// ----- rtl/grk_pkg.sv -----
// ----------------------------------------------------------------------------
// grk_pkg
// Shared types for the group reversal block: the shift control carried from
// the controller to each storage cell of the chain.
// ----------------------------------------------------------------------------
package grk_pkg;

    // Per-cycle shift command for the cell chain.
    // push: every cell takes its lower neighbour's word (a new word enters cell 0).
    // pop : every cell takes its upper neighbour's word (cell 0 leaves the chain).
    typedef struct packed {
        logic push;
        logic pop;
    } grk_shift_t;

endpackage

// ----- rtl/group_reverse_k.sv -----
// ----------------------------------------------------------------------------
// group_reverse_k
// Reverses a word stream in groups of group_size elements.
//
// Input channel (s_*): one list element per transfer, s_list_end on the last.
// Result channel (m_*): reordered words; m_run_last marks the last result
// caused by one input transfer, m_list_done the last word of the list.
// Configuration channel (cfg_*): writes group_size (0 acts as 1, values above
// MAX_GROUP act as MAX_GROUP). cfg_ready is always high; write only while idle.
//
// Words enter a chain of MAX_GROUP cells, newest in cell 0. While a group
// fills, one element is taken per cycle. When the group is full the chain
// pops towards cell 0, giving newest first; when the list ends early the
// words leave oldest first, read from the far end of the occupied cells.
// A group of n words drains as n results, one result per cycle while the
// receiver is ready; no input is taken during the drain. The transfer
// that completes a group sets the drain flag, then the first result loads
// the output register. A stalled receiver holds it and freezes the drain.
// Reset empties the chain, drops any pending result and sets group_size to 1.
// ----------------------------------------------------------------------------
module group_reverse_k #(
    parameter int MAX_GROUP = 16,
    parameter int WORD_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [4:0]           cfg_group_size,
    // input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_BITS-1:0] s_element_value,
    input  logic                 s_list_end,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_BITS-1:0] m_out_value,
    output logic                 m_run_last,
    output logic                 m_list_done
);
    import grk_pkg::*;

    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    // control state
    logic [4:0]           gsize_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 drain_reg;   // emptying the chain
    logic                 rev_reg;     // drain newest first
    logic                 end_reg;     // drained group closes the list
    logic                 m_valid_reg;

    // result payload
    logic [WORD_BITS-1:0] m_value_reg;
    logic                 m_run_last_reg;
    logic                 m_done_reg;

    logic [CNT_W-1:0]     k_eff;
    logic [CNT_W-1:0]     count_plus;
    logic [IDX_W-1:0]     rd_idx;
    logic                 accept_in;
    logic                 slot_free;
    logic                 pop_go;
    logic                 last_pop;
    logic [WORD_BITS-1:0] pop_word;
    grk_shift_t           shift;

    logic [WORD_BITS-1:0] cell_q [MAX_GROUP];

    // clamp the configured size to the legal range
    always_comb begin
        if (gsize_reg == 5'd0) begin
            k_eff = CNT_W'(1);
        end else if (int'(gsize_reg) > MAX_GROUP) begin
            k_eff = CNT_W'(MAX_GROUP);
        end else begin
            k_eff = CNT_W'(gsize_reg);
        end
    end

    assign cfg_ready  = 1'b1;
    assign s_ready    = !drain_reg;
    assign accept_in  = s_valid && !drain_reg;
    assign slot_free  = !m_valid_reg || m_ready;
    assign pop_go     = drain_reg && slot_free;
    assign last_pop   = (count_reg == CNT_W'(1));
    assign count_plus = count_reg + CNT_W'(1);
    assign rd_idx     = IDX_W'(count_reg - CNT_W'(1));

    // newest first from cell 0, oldest first from the top occupied cell
    assign pop_word   = rev_reg ? cell_q[0] : cell_q[rd_idx];

    assign shift.push = accept_in;
    assign shift.pop  = pop_go && rev_reg;

    // storage chain
    for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
        logic [WORD_BITS-1:0] lower_d;
        logic [WORD_BITS-1:0] upper_d;

        if (i == 0) begin : g_first
            assign lower_d = s_element_value;
        end else begin : g_mid_lo
            assign lower_d = cell_q[i-1];
        end

        if (i == MAX_GROUP - 1) begin : g_last
            assign upper_d = '0;
        end else begin : g_mid_hi
            assign upper_d = cell_q[i+1];
        end

        grk_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (shift),
            .lower_d (lower_d),
            .upper_d (upper_d),
            .q       (cell_q[i])
        );
    end

    // fill and drain control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gsize_reg   <= 5'd1;
            count_reg   <= '0;
            drain_reg   <= 1'b0;
            rev_reg     <= 1'b0;
            end_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                gsize_reg <= cfg_group_size;
            end

            if (accept_in) begin
                count_reg <= count_plus;
                // full group: drain reversed; short tail at list end: drain in order
                if (count_plus >= k_eff) begin
                    drain_reg <= 1'b1;
                    rev_reg   <= 1'b1;
                    end_reg   <= s_list_end;
                end else if (s_list_end) begin
                    drain_reg <= 1'b1;
                    rev_reg   <= 1'b0;
                    end_reg   <= 1'b1;
                end
            end

            if (pop_go) begin
                m_valid_reg <= 1'b1;
                count_reg   <= count_reg - CNT_W'(1);
                if (last_pop) begin
                    drain_reg <= 1'b0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output payload: load on each pop, hold while stalled
    always_ff @(posedge aclk) begin
        if (pop_go) begin
            m_value_reg    <= pop_word;
            m_run_last_reg <= last_pop;
            m_done_reg     <= last_pop && end_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_value = m_value_reg;
    assign m_run_last  = m_run_last_reg;
    assign m_list_done = m_done_reg;

endmodule

// ----- rtl/grk_cell.sv -----
// ----------------------------------------------------------------------------
// grk_cell
// One storage cell of the chain: holds a single word and loads it from the
// lower or the upper neighbour as the shift command says.
// ----------------------------------------------------------------------------
module grk_cell #(
    parameter int WORD_BITS = 16
) (
    input  logic                   aclk,
    input  grk_pkg::grk_shift_t    ctrl,
    input  logic [WORD_BITS-1:0]   lower_d,
    input  logic [WORD_BITS-1:0]   upper_d,
    output logic [WORD_BITS-1:0]   q
);
    import grk_pkg::*;

    logic [WORD_BITS-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            data_reg <= lower_d;
        end else if (ctrl.pop) begin
            data_reg <= upper_d;
        end
    end

    assign q = data_reg;

endmodule
